### hdl/mmf_pkg.sv
// Shared types and codes for the min/max FIFO.
package mmf_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned OCC_W  = 5;

    typedef logic signed [DATA_W-1:0] t_data;

    typedef logic [0:0] t_cmd;
    localparam t_cmd CMD_PUSH = 1'b0;
    localparam t_cmd CMD_POP  = 1'b1;

    typedef logic [1:0] t_status;
    localparam t_status STATUS_DONE       = 2'd0;
    localparam t_status STATUS_PUSH_FULL  = 2'd1;
    localparam t_status STATUS_POP_EMPTY  = 2'd2;

    typedef logic [1:0] t_kind;
    localparam t_kind KIND_QUEUE = 2'd0;
    localparam t_kind KIND_MIN   = 2'd1;
    localparam t_kind KIND_MAX   = 2'd2;

    typedef struct packed {
        logic push;
        logic pop;
    } t_chain_ctrl;

    typedef struct packed {
        logic push;
        logic shift;
    } t_cell_ctrl;

endpackage

### hdl/mmf_cell.sv
// One storage cell of a queue, min or max chain.
module mmf_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mmf_pkg::t_kind     i_kind,
    input  mmf_pkg::t_cell_ctrl i_ctrl,
    input  mmf_pkg::t_data     i_value,
    input  logic               i_prev_keep,
    input  mmf_pkg::t_data     i_next_value,
    input  logic               i_next_valid,
    output mmf_pkg::t_data     o_value,
    output logic               o_valid,
    output logic               o_keep
);

    mmf_pkg::t_data r_value, n_value;
    logic           r_valid, n_valid;
    logic           w_keep;

    always_comb begin
        case (i_kind)
            mmf_pkg::KIND_QUEUE: w_keep = r_valid;
            mmf_pkg::KIND_MIN:   w_keep = r_valid && !(i_value < r_value);
            mmf_pkg::KIND_MAX:   w_keep = r_valid && !(r_value < i_value);
            default:             w_keep = r_valid;
        endcase
    end

    always_comb begin
        n_value = r_value;
        n_valid = r_valid;
        if (i_ctrl.push) begin
            n_valid = w_keep || i_prev_keep;
            if (i_prev_keep && !w_keep) begin
                n_value = i_value;
            end
        end else if (i_ctrl.shift) begin
            n_valid = i_next_valid;
            n_value = i_next_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;
    assign o_valid = r_valid;
    assign o_keep  = w_keep;

endmodule

### hdl/mmf_chain.sv
// Row of cells forming the queue or one of the min/max chains.
module mmf_chain #(
    parameter int unsigned DEPTH = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  mmf_pkg::t_kind       i_kind,
    input  mmf_pkg::t_chain_ctrl i_ctrl,
    input  mmf_pkg::t_data       i_value,
    input  mmf_pkg::t_data       i_pop_value,
    output mmf_pkg::t_data       o_head_value,
    output logic                 o_head_valid
);

    mmf_pkg::t_data w_value      [DEPTH];
    logic           w_valid      [DEPTH];
    logic           w_keep       [DEPTH];
    logic           w_shift;
    mmf_pkg::t_cell_ctrl w_cell_ctrl;

    assign w_shift = i_ctrl.pop && w_valid[0] &&
                     ((i_kind == mmf_pkg::KIND_QUEUE) || (w_value[0] == i_pop_value));

    assign w_cell_ctrl.push  = i_ctrl.push;
    assign w_cell_ctrl.shift = w_shift;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic           w_prev_keep;
        mmf_pkg::t_data w_right_value;
        logic           w_right_valid;

        if (g == 0) begin : g_first
            assign w_prev_keep = 1'b1;
        end else begin : g_inner
            assign w_prev_keep = w_keep[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign w_right_value = '0;
            assign w_right_valid = 1'b0;
        end else begin : g_mid
            assign w_right_value = w_value[g+1];
            assign w_right_valid = w_valid[g+1];
        end

        mmf_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_kind       (i_kind),
            .i_ctrl       (w_cell_ctrl),
            .i_value      (i_value),
            .i_prev_keep  (w_prev_keep),
            .i_next_value (w_right_value),
            .i_next_valid (w_right_valid),
            .o_value      (w_value[g]),
            .o_valid      (w_valid[g]),
            .o_keep       (w_keep[g])
        );
    end

    assign o_head_value = w_value[0];
    assign o_head_valid = w_valid[0];

endmodule

### hdl/min_max_fifo.sv
// Top level of the min/max FIFO: queue, min chain, max chain and result register.
// A FIFO of signed 32-bit words that reports front, minimum and maximum after
// every push or pop. The queue and both monotonic chains are rows of DEPTH
// cells; a push compares the new word against every chain cell at once, a pop
// shifts the queue by one cell and each chain only when its head equals the
// popped front; a new word is accepted each cycle while the result register
// is free or being read, and results show in the next cycle. A push to a full
// queue is dropped with status 1, a pop from an empty queue is ignored with
// status 2, and front, min and max read 0 while the queue is empty.
module min_max_fifo #(
    parameter int unsigned DEPTH = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic                    i_cmd,
    input  logic signed [31:0]      i_value,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic signed [31:0]      o_front_value,
    output logic signed [31:0]      o_min_value,
    output logic signed [31:0]      o_max_value,
    output logic [4:0]              o_occupancy,
    output logic [1:0]              o_status
);

    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic                  w_accept;
    logic                  w_full;
    logic                  w_push_ok;
    logic                  w_pop_ok;
    mmf_pkg::t_chain_ctrl  w_ctrl;
    mmf_pkg::t_status      w_status;

    mmf_pkg::t_data        w_q_head;
    logic                  w_q_head_valid;
    mmf_pkg::t_data        w_min_head;
    logic                  w_min_head_valid;
    mmf_pkg::t_data        w_max_head;
    logic                  w_max_head_valid;

    logic [CNT_W-1:0]      r_count, n_count;
    logic                  r_out_valid;
    logic [mmf_pkg::OCC_W-1:0] r_occ;
    mmf_pkg::t_status      r_status;

    assign o_ready   = !r_out_valid || i_ready;
    assign w_accept  = i_valid && o_ready;
    assign w_full    = (r_count == CNT_W'(DEPTH));
    assign w_push_ok = w_accept && (i_cmd == mmf_pkg::CMD_PUSH) && !w_full;
    assign w_pop_ok  = w_accept && (i_cmd == mmf_pkg::CMD_POP) && w_q_head_valid;

    assign w_ctrl.push = w_push_ok;
    assign w_ctrl.pop  = w_pop_ok;

    always_comb begin
        w_status = mmf_pkg::STATUS_DONE;
        if (i_cmd == mmf_pkg::CMD_PUSH) begin
            if (w_full) begin
                w_status = mmf_pkg::STATUS_PUSH_FULL;
            end
        end else if (!w_q_head_valid) begin
            w_status = mmf_pkg::STATUS_POP_EMPTY;
        end
    end

    always_comb begin
        n_count = r_count;
        if (w_push_ok) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_pop_ok) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    mmf_chain #(.DEPTH(DEPTH)) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_kind       (mmf_pkg::KIND_QUEUE),
        .i_ctrl       (w_ctrl),
        .i_value      (i_value),
        .i_pop_value  (w_q_head),
        .o_head_value (w_q_head),
        .o_head_valid (w_q_head_valid)
    );

    mmf_chain #(.DEPTH(DEPTH)) u_min (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_kind       (mmf_pkg::KIND_MIN),
        .i_ctrl       (w_ctrl),
        .i_value      (i_value),
        .i_pop_value  (w_q_head),
        .o_head_value (w_min_head),
        .o_head_valid (w_min_head_valid)
    );

    mmf_chain #(.DEPTH(DEPTH)) u_max (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_kind       (mmf_pkg::KIND_MAX),
        .i_ctrl       (w_ctrl),
        .i_value      (i_value),
        .i_pop_value  (w_q_head),
        .o_head_value (w_max_head),
        .o_head_valid (w_max_head_valid)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Hold the result word until the consumer takes it.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_occ    <= mmf_pkg::OCC_W'(n_count);
            r_status <= w_status;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_front_value = w_q_head_valid ? w_q_head : '0;
    assign o_min_value   = (w_q_head_valid && w_min_head_valid) ? w_min_head : '0;
    assign o_max_value   = (w_q_head_valid && w_max_head_valid) ? w_max_head : '0;
    assign o_occupancy   = r_occ;
    assign o_status      = r_status;

endmodule
